// File: src/nps_pkg.sv
package nps_pkg;

   localparam int MAX_PROCS_DEFAULT = 16;

   localparam int ARR_W     = 16;
   localparam int BURST_W   = 16;
   localparam int PRIO_W    = 8;
   localparam int TIME_W    = 21;
   localparam int JOB_IDX_W = 4;

   // Running selection result handed from cell to cell during a scan.
   typedef struct packed {
      logic               found;   // a ready job has been picked
      logic [PRIO_W-1:0]  prio;
      logic [ARR_W-1:0]   arr;
      logic [BURST_W-1:0] burst;
      logic               any;     // some unfinished job has been seen
      logic [ARR_W-1:0]   e_arr;   // earliest unfinished arrival
   } cand_type;

   typedef struct packed {
      logic clear;   // drop the whole job set
      logic load;    // write the job at load_idx
      logic mark;    // retire the job at mark_idx
   } cell_ctl_type;

endpackage

// File: src/nps_cell.sv
module nps_cell #(
   parameter int CELL_IDX = 0,
   parameter int IDX_W    = 4,
   parameter int CNT_W    = 5
) (
   input  logic                            clock,
   input  logic                            reset,
   input  nps_pkg::cell_ctl_type           ctl,
   input  logic [CNT_W-1:0]                load_idx,
   input  logic [IDX_W-1:0]                mark_idx,
   input  logic [nps_pkg::ARR_W-1:0]       load_arr,
   input  logic [nps_pkg::BURST_W-1:0]     load_burst,
   input  logic [nps_pkg::PRIO_W-1:0]      load_prio,
   input  logic [nps_pkg::TIME_W-1:0]      now,
   input  logic                            tok_i,
   input  nps_pkg::cand_type               cand_i,
   input  logic [IDX_W-1:0]                idx_i,
   output logic                            tok_o,
   output nps_pkg::cand_type               cand_o,
   output logic [IDX_W-1:0]                idx_o
);

   localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(CELL_IDX);
   localparam logic [CNT_W-1:0] MY_SLOT = CNT_W'(CELL_IDX);

   logic [nps_pkg::ARR_W-1:0]   arr_ff;
   logic [nps_pkg::BURST_W-1:0] burst_ff;
   logic [nps_pkg::PRIO_W-1:0]  prio_ff;
   logic                        loaded_ff, loaded_in;
   logic                        done_ff, done_in;
   logic                        tok_ff;
   nps_pkg::cand_type           cand_ff, cand_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;

   logic load_hit, eligible, ready, take_ready, take_early;

   assign load_hit = ctl.load && (load_idx == MY_SLOT);
   assign eligible = loaded_ff && !done_ff;
   assign ready    = eligible &&
                     ({{(nps_pkg::TIME_W-nps_pkg::ARR_W){1'b0}}, arr_ff} <= now);

   // Scan runs from index 0 up, so strict compares keep the lower index on ties.
   assign take_ready = ready && (!cand_i.found || (prio_ff < cand_i.prio) ||
                                 ((prio_ff == cand_i.prio) && (arr_ff < cand_i.arr)));
   assign take_early = eligible && (!cand_i.any || (arr_ff < cand_i.e_arr));

   always_comb begin
      cand_in = cand_i;
      idx_in  = idx_i;
      if (take_ready) begin
         cand_in.found = 1'b1;
         cand_in.prio  = prio_ff;
         cand_in.arr   = arr_ff;
         cand_in.burst = burst_ff;
         idx_in        = MY_IDX;
      end
      if (take_early) begin
         cand_in.any   = 1'b1;
         cand_in.e_arr = arr_ff;
      end
   end

   always_comb begin
      loaded_in = loaded_ff;
      done_in   = done_ff;
      if (ctl.clear) begin
         loaded_in = 1'b0;
         done_in   = 1'b0;
      end else if (load_hit) begin
         loaded_in = 1'b1;
         done_in   = 1'b0;
      end else if (ctl.mark && (mark_idx == MY_IDX)) begin
         done_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= 1'b0;
         done_ff   <= 1'b0;
         tok_ff    <= 1'b0;
      end else begin
         loaded_ff <= loaded_in;
         done_ff   <= done_in;
         tok_ff    <= tok_i;
      end
   end

   always_ff @(posedge clock) begin
      if (load_hit) begin
         arr_ff   <= load_arr;
         burst_ff <= load_burst;
         prio_ff  <= load_prio;
      end
      cand_ff <= cand_in;
      idx_ff  <= idx_in;
   end

   assign tok_o  = tok_ff;
   assign cand_o = cand_ff;
   assign idx_o  = idx_ff;

endmodule

// File: src/nonpreemptive_priority_scheduler.sv
// Non-preemptive priority scheduler.
// Input channel: a transfer happens on a clock edge with start high and busy low,
// carrying one job (req_arrival_time, req_burst_time, req_job_priority). Jobs
// are stored in load order, one per cycle; loads past MAX_PROCS are dropped.
// A transfer with req_last_job set closes the set and starts scheduling; busy
// then stays high until the final segment has been sent.
// Result channel: one Gantt segment (a job run or an idle gap) per rsp_valid
// strobe, in time order. The strobe lasts one cycle and cannot be held off.
// rsp_last_segment marks the run that completes the final job; the same cycle
// busy drops and a new job set may be loaded.
// Scheduling: each segment costs one scan down the cell chain, since the
// selection token visits every cell once. When no job arrives at tick 0, a
// first scan finds the earliest arrival and emits nothing.
// Reset empties the job table, clears the time base and drops any scan.
module nonpreemptive_priority_scheduler #(
   parameter int MAX_PROCS = nps_pkg::MAX_PROCS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [nps_pkg::ARR_W-1:0]         req_arrival_time,
   input  logic [nps_pkg::BURST_W-1:0]       req_burst_time,
   input  logic [nps_pkg::PRIO_W-1:0]        req_job_priority,
   input  logic                              req_last_job,
   output logic                              rsp_valid,
   output logic                              rsp_is_idle,
   output logic [nps_pkg::JOB_IDX_W-1:0]     rsp_job_index,
   output logic [nps_pkg::TIME_W-1:0]        rsp_start_time,
   output logic [nps_pkg::TIME_W-1:0]        rsp_end_time,
   output logic [nps_pkg::TIME_W-1:0]        rsp_turnaround,
   output logic [nps_pkg::TIME_W-1:0]        rsp_waiting,
   output logic                              rsp_last_segment
);

   localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W = $clog2(MAX_PROCS + 1);
   localparam int TW    = nps_pkg::TIME_W;
   localparam int PAD_W = nps_pkg::TIME_W - nps_pkg::ARR_W;
   localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_PROCS);

   // controller states
   localparam logic [1:0] ST_LOAD  = 2'd0;   // taking jobs
   localparam logic [1:0] ST_START = 2'd1;   // launch a scan token
   localparam logic [1:0] ST_WAIT  = 2'd2;   // token travels down the chain

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;         // jobs held
   logic [CNT_W-1:0] fin_ff, fin_in;         // jobs completed in this set
   logic [TW-1:0]    now_ff, now_in;
   logic             init_ff, init_in;       // time base not yet set

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_idle_ff, rsp_idle_in;
   logic [nps_pkg::JOB_IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [TW-1:0]        rsp_st_ff, rsp_st_in;
   logic [TW-1:0]        rsp_en_ff, rsp_en_in;
   logic [TW-1:0]        rsp_tt_ff, rsp_tt_in;
   logic [TW-1:0]        rsp_wt_ff, rsp_wt_in;
   logic                 rsp_last_ff, rsp_last_in;

   nps_pkg::cell_ctl_type ctl;
   logic [IDX_W-1:0]      mark_idx;

   // chain wiring: entry 0 is the seed, entry MAX_PROCS the chain output
   logic                  tok_bus  [MAX_PROCS+1];
   nps_pkg::cand_type     cand_bus [MAX_PROCS+1];
   logic [IDX_W-1:0]      idx_bus  [MAX_PROCS+1];

   logic                  accept;
   nps_pkg::cand_type     res;
   logic [TW-1:0]         res_arr, res_burst, res_early, run_end, run_wait, run_turn;
   logic [CNT_W-1:0]      fin_next;

   assign busy   = (state_ff != ST_LOAD);
   assign accept = start && !busy;

   assign tok_bus[0]  = (state_ff == ST_START);
   assign cand_bus[0] = '0;
   assign idx_bus[0]  = '0;

   for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
      nps_cell #(
         .CELL_IDX (g),
         .IDX_W    (IDX_W),
         .CNT_W    (CNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .load_idx   (cnt_ff),
         .mark_idx   (mark_idx),
         .load_arr   (req_arrival_time),
         .load_burst (req_burst_time),
         .load_prio  (req_job_priority),
         .now        (now_ff),
         .tok_i      (tok_bus[g]),
         .cand_i     (cand_bus[g]),
         .idx_i      (idx_bus[g]),
         .tok_o      (tok_bus[g+1]),
         .cand_o     (cand_bus[g+1]),
         .idx_o      (idx_bus[g+1])
      );
   end

   // scan outcome and segment arithmetic (all from now, in parallel)
   assign res       = cand_bus[MAX_PROCS];
   assign mark_idx  = idx_bus[MAX_PROCS];
   assign res_arr   = {{PAD_W{1'b0}}, res.arr};
   assign res_burst = {{PAD_W{1'b0}}, res.burst};
   assign res_early = {{PAD_W{1'b0}}, res.e_arr};
   assign run_end   = now_ff + res_burst;
   assign run_wait  = now_ff - res_arr;
   assign run_turn  = now_ff - res_arr + res_burst;
   assign fin_next  = fin_ff + CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      fin_in       = fin_ff;
      now_in       = now_ff;
      init_in      = init_ff;
      ctl          = '0;
      rsp_valid_in = 1'b0;
      rsp_idle_in  = rsp_idle_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_en_in    = rsp_en_ff;
      rsp_tt_in    = rsp_tt_ff;
      rsp_wt_in    = rsp_wt_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (cnt_ff != FULL) begin
                  ctl.load = 1'b1;
                  cnt_in   = cnt_ff + CNT_W'(1);
               end
               if (req_last_job) begin
                  state_in = ST_START;
                  fin_in   = '0;
                  now_in   = '0;
                  init_in  = 1'b1;
               end
            end
         end
         ST_START: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (tok_bus[MAX_PROCS]) begin
               if (res.found) begin
                  // run the selected job to completion
                  ctl.mark     = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_idle_in  = 1'b0;
                  rsp_idx_in   = nps_pkg::JOB_IDX_W'(mark_idx);
                  rsp_st_in    = now_ff;
                  rsp_en_in    = run_end;
                  rsp_tt_in    = run_turn;
                  rsp_wt_in    = run_wait;
                  rsp_last_in  = (fin_next == cnt_ff);
                  now_in       = run_end;
                  fin_in       = fin_next;
                  init_in      = 1'b0;
                  state_in     = ST_START;
                  if (fin_next == cnt_ff) begin
                     ctl.clear = 1'b1;
                     cnt_in    = '0;
                     fin_in    = '0;
                     now_in    = '0;
                     init_in   = 1'b1;
                     state_in  = ST_LOAD;
                  end
               end else if (res.any) begin
                  // nothing ready: jump to the earliest pending arrival;
                  // the very first jump only sets the time base
                  if (!init_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_idle_in  = 1'b1;
                     rsp_idx_in   = '0;
                     rsp_st_in    = now_ff;
                     rsp_en_in    = res_early;
                     rsp_tt_in    = '0;
                     rsp_wt_in    = '0;
                     rsp_last_in  = 1'b0;
                  end
                  now_in   = res_early;
                  init_in  = 1'b0;
                  state_in = ST_START;
               end else begin
                  ctl.clear = 1'b1;
                  cnt_in    = '0;
                  fin_in    = '0;
                  now_in    = '0;
                  init_in   = 1'b1;
                  state_in  = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         fin_ff       <= '0;
         now_ff       <= '0;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fin_ff       <= fin_in;
         now_ff       <= now_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_idle_ff <= rsp_idle_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_en_ff   <= rsp_en_in;
      rsp_tt_ff   <= rsp_tt_in;
      rsp_wt_ff   <= rsp_wt_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_idle      = rsp_idle_ff;
   assign rsp_job_index    = rsp_idx_ff;
   assign rsp_start_time   = rsp_st_ff;
   assign rsp_end_time     = rsp_en_ff;
   assign rsp_turnaround   = rsp_tt_ff;
   assign rsp_waiting      = rsp_wt_ff;
   assign rsp_last_segment = rsp_last_ff;

   // completed count stays below the set size while scheduling
   a_fin_below_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> (fin_ff < cnt_ff))
      else $error("completed count reached set size mid-schedule");

   // an idle gap always moves time forward
   a_idle_forward: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_idle) |-> (rsp_end_time > rsp_start_time))
      else $error("idle segment does not advance time");

   // final segment returns the block to loading with an empty table
   a_last_to_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_segment) |-> ((state_ff == ST_LOAD) && (cnt_ff == '0)))
      else $error("final segment without return to load");

   // a scan launch always moves on to waiting for its token to leave the chain
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_START) |=> (state_ff == ST_WAIT))
      else $error("scan launch not followed by wait");

endmodule
